// File: hdl/alu_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// alu_pkg
// Shared types and constants of the pipelined 32-bit ALU.
// ----------------------------------------------------------------------------
package alu_pkg;

    localparam int WORD_W     = 32;
    localparam int CMD_W      = 3;
    localparam int DIV_STAGES = WORD_W;

    typedef enum logic [CMD_W-1:0] {
        CMD_AND = 3'b000,
        CMD_OR  = 3'b001,
        CMD_XOR = 3'b010,
        CMD_SHR = 3'b011,
        CMD_SHL = 3'b100,
        CMD_ADD = 3'b101,
        CMD_MUL = 3'b110,
        CMD_DIV = 3'b111
    } alu_cmd_t;

    // word carried down the pipe
    typedef struct packed {
        alu_cmd_t            cmd;
        logic [WORD_W-1:0]   res;    // result of every command but divide
        logic                ovf;
        logic                dbz;    // divide by zero
        logic                neg_q;  // quotient gets negated
        logic [WORD_W-1:0]   rem;    // partial remainder
        logic [WORD_W-1:0]   dvd;    // dividend bits in, quotient bits out
        logic [WORD_W-1:0]   dsr;    // divisor magnitude
    } alu_stage_t;

endpackage

// File: hdl/alu_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// alu_if
// Valid/ready channels of the ALU: request word and response word.
// ----------------------------------------------------------------------------
interface alu_req_if;
    logic        valid;
    logic        ready;
    logic [2:0]  command;
    logic [31:0] operand_a;
    logic [31:0] operand_b;

    modport source (output valid, output command, output operand_a, output operand_b,
                    input ready);
    modport sink   (input valid, input command, input operand_a, input operand_b,
                    output ready);
endinterface

interface alu_rsp_if;
    logic        valid;
    logic        ready;
    logic [31:0] result;
    logic        zero_flag;
    logic        overflow_flag;
    logic        negative_flag;

    modport source (output valid, output result, output zero_flag, output overflow_flag,
                    output negative_flag, input ready);
    modport sink   (input valid, input result, input zero_flag, input overflow_flag,
                    input negative_flag, output ready);
endinterface

// File: hdl/alu_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// alu_front
// First stage: logic ops, shifts, add with overflow, low product, and
// operand magnitudes for the divider.
// ----------------------------------------------------------------------------
module alu_front (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               advance,
    alu_req_if.sink            req,
    output logic               valid_reg,
    output alu_pkg::alu_stage_t stage_reg
);
    import alu_pkg::*;

    alu_cmd_t          cmd;
    logic [WORD_W-1:0] a;
    logic [WORD_W-1:0] b;
    logic [WORD_W-1:0] sum;
    logic [WORD_W-1:0] prod;
    alu_stage_t        stage_next;

    assign cmd  = alu_cmd_t'(req.command);
    assign a    = req.operand_a;
    assign b    = req.operand_b;
    assign sum  = a + b;
    assign prod = a * b;

    always_comb
    begin
        stage_next       = '0;
        stage_next.cmd   = cmd;
        stage_next.dbz   = (b == '0);
        stage_next.neg_q = a[WORD_W-1] ^ b[WORD_W-1];
        stage_next.dvd   = a[WORD_W-1] ? (~a + 1'b1) : a;
        stage_next.dsr   = b[WORD_W-1] ? (~b + 1'b1) : b;
        case (cmd)
            CMD_AND: stage_next.res = a & b;
            CMD_OR:  stage_next.res = a | b;
            CMD_XOR: stage_next.res = a ^ b;
            CMD_SHR: stage_next.res = {1'b0, a[WORD_W-1:1]};
            CMD_SHL: stage_next.res = {a[WORD_W-2:0], 1'b0};
            CMD_ADD:
            begin
                stage_next.res = sum;
                stage_next.ovf = ~(a[WORD_W-1] ^ b[WORD_W-1]) & (a[WORD_W-1] ^ sum[WORD_W-1]);
            end
            CMD_MUL: stage_next.res = prod;
            default: stage_next.res = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            valid_reg <= req.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            stage_reg <= stage_next;
        end
    end

endmodule

// File: hdl/alu_div_step.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// alu_div_step
// One restoring-division step: one quotient bit per stage.
// ----------------------------------------------------------------------------
module alu_div_step (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                advance,
    input  logic                valid_in,
    input  alu_pkg::alu_stage_t stage_in,
    output logic                valid_reg,
    output alu_pkg::alu_stage_t stage_reg
);
    import alu_pkg::*;

    logic [WORD_W:0]   shifted;
    logic [WORD_W:0]   diff;
    logic              fits;
    alu_stage_t        stage_next;

    assign shifted = {stage_in.rem, stage_in.dvd[WORD_W-1]};
    assign diff    = shifted - {1'b0, stage_in.dsr};
    assign fits    = (shifted >= {1'b0, stage_in.dsr});

    always_comb
    begin
        stage_next     = stage_in;
        stage_next.rem = fits ? diff[WORD_W-1:0] : shifted[WORD_W-1:0];
        stage_next.dvd = {stage_in.dvd[WORD_W-2:0], fits};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            valid_reg <= valid_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            stage_reg <= stage_next;
        end
    end

endmodule

// File: hdl/alu_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// alu_back
// Last stage: quotient sign fix, result select, flags, output register.
// ----------------------------------------------------------------------------
module alu_back (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                valid_in,
    input  alu_pkg::alu_stage_t stage_in,
    output logic                advance,
    alu_rsp_if.source           rsp
);
    import alu_pkg::*;

    logic              valid_reg;
    logic [WORD_W-1:0] result_reg;
    logic              ovf_reg;
    logic [WORD_W-1:0] quot;
    logic [WORD_W-1:0] result_next;

    assign advance = !valid_reg || rsp.ready;

    always_comb
    begin
        if (stage_in.dbz)
        begin
            quot = '1;
        end
        else if (stage_in.neg_q)
        begin
            quot = ~stage_in.dvd + 1'b1;
        end
        else
        begin
            quot = stage_in.dvd;
        end
        result_next = (stage_in.cmd == CMD_DIV) ? quot : stage_in.res;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            valid_reg <= valid_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            result_reg <= result_next;
            ovf_reg    <= stage_in.ovf;
        end
    end

    assign rsp.valid         = valid_reg;
    assign rsp.result        = result_reg;
    assign rsp.zero_flag     = (result_reg == '0);
    assign rsp.overflow_flag = ovf_reg;
    assign rsp.negative_flag = result_reg[WORD_W-1];

endmodule

// File: hdl/alu_32bit_eight_op_with_flags_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// alu_32bit_eight_op_with_flags_unit
// Pipelined 32-bit ALU: and, or, xor, shifts, add, multiply, divide, flags.
// ----------------------------------------------------------------------------
// Every command passes through the front stage, the 32 divider steps and the output register.
// Throughput: one word per cycle while the output is not stalled; the one-bit-per-stage divider sets the depth.
// A stall at the output freezes all stages; nothing is dropped or repeated.
// Reset clears all valid bits at once; no warm-up pass.
module alu_32bit_eight_op_with_flags_unit (
    input  logic      clk,
    input  logic      rst_n,
    alu_req_if.sink   req,
    alu_rsp_if.source rsp
);
    import alu_pkg::*;

    logic       advance;
    logic       front_valid;
    alu_stage_t front_stage;
    logic       step_valid [DIV_STAGES];
    alu_stage_t step_stage [DIV_STAGES];

    assign req.ready = advance;

    alu_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .advance   (advance),
        .req       (req),
        .valid_reg (front_valid),
        .stage_reg (front_stage)
    );

    for (genvar i = 0; i < DIV_STAGES; i++)
    begin : g_div
        if (i == 0)
        begin : g_first
            alu_div_step u_step (
                .clk       (clk),
                .rst_n     (rst_n),
                .advance   (advance),
                .valid_in  (front_valid),
                .stage_in  (front_stage),
                .valid_reg (step_valid[i]),
                .stage_reg (step_stage[i])
            );
        end
        else
        begin : g_next
            alu_div_step u_step (
                .clk       (clk),
                .rst_n     (rst_n),
                .advance   (advance),
                .valid_in  (step_valid[i-1]),
                .stage_in  (step_stage[i-1]),
                .valid_reg (step_valid[i]),
                .stage_reg (step_stage[i])
            );
        end
    end

    alu_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .valid_in (step_valid[DIV_STAGES-1]),
        .stage_in (step_stage[DIV_STAGES-1]),
        .advance  (advance),
        .rsp      (rsp)
    );

    a_stall_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && !rsp.ready) |-> !req.ready)
        else $error("input taken while output stalled");

    a_accept_enters_pipe: assert property (@(posedge clk) disable iff (!rst_n)
        (req.valid && req.ready) |=> front_valid)
        else $error("accepted word missing from first stage");

    a_div_zero_all_ones: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && step_valid[DIV_STAGES-1] && step_stage[DIV_STAGES-1].dbz
         && step_stage[DIV_STAGES-1].cmd == CMD_DIV) |=> (rsp.valid && rsp.result == '1))
        else $error("divide by zero did not give all ones");

    a_ovf_add_only: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && step_valid[DIV_STAGES-1] && step_stage[DIV_STAGES-1].cmd != CMD_ADD)
        |=> !rsp.overflow_flag)
        else $error("overflow flag set outside add");

    a_last_stage_delivers: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && step_valid[DIV_STAGES-1]) |=> rsp.valid)
        else $error("word lost at output stage");

endmodule

// File: tb/sv/alu_result_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// alu_result_checker
// Watches the request and response channels of the ALU. Computes the result
// and flags for every accepted request word, then compares each response word
// against the oldest outstanding prediction.
// ----------------------------------------------------------------------------
module alu_result_checker (
    input  logic        clk,
    input  logic        rst_n,
    alu_req_if          req,
    alu_rsp_if          rsp,
    output int unsigned fail_count,
    output int unsigned pending
);
    import alu_pkg::*;

    typedef struct packed {
        logic [WORD_W-1:0] result;
        logic              zero;
        logic              ovf;
        logic              neg;
    } alu_rsp_word_t;

    alu_rsp_word_t pending_rsp_q[$];
    int unsigned   mismatches  = 0;
    int unsigned   pending_cnt = 0;

    assign fail_count = mismatches;
    assign pending    = pending_cnt;

    // signed divide, truncating toward zero; x/0 gives all ones
    function automatic logic [WORD_W-1:0] signed_quotient(input logic [WORD_W-1:0] a,
                                                          input logic [WORD_W-1:0] b);
        logic [WORD_W-1:0] mag_a;
        logic [WORD_W-1:0] mag_b;
        logic [WORD_W-1:0] q;
        if (b == '0)
            return '1;
        mag_a = a[WORD_W-1] ? -a : a;
        mag_b = b[WORD_W-1] ? -b : b;
        q     = mag_a / mag_b;
        return (a[WORD_W-1] ^ b[WORD_W-1]) ? -q : q;
    endfunction

    function automatic alu_rsp_word_t alu_eval(input alu_cmd_t cmd,
                                               input logic [WORD_W-1:0] a,
                                               input logic [WORD_W-1:0] b);
        alu_rsp_word_t       w;
        logic [2*WORD_W-1:0] prod;
        w = '0;
        case (cmd)
            CMD_AND: w.result = a & b;
            CMD_OR:  w.result = a | b;
            CMD_XOR: w.result = a ^ b;
            CMD_SHR: w.result = a >> 1;
            CMD_SHL: w.result = a << 1;
            CMD_ADD:
            begin
                w.result = a + b;
                w.ovf    = (a[WORD_W-1] == b[WORD_W-1]) && (w.result[WORD_W-1] != a[WORD_W-1]);
            end
            CMD_MUL:
            begin
                prod     = {{WORD_W{1'b0}}, a} * {{WORD_W{1'b0}}, b};
                w.result = prod[WORD_W-1:0];
            end
            default: w.result = signed_quotient(a, b);
        endcase
        w.zero = (w.result == '0);
        w.neg  = w.result[WORD_W-1];
        return w;
    endfunction

    task automatic check_field(input string name, input logic [WORD_W-1:0] exp_v,
                               input logic [WORD_W-1:0] act_v);
        if (exp_v !== act_v)
        begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, exp_v, act_v);
            mismatches++;
        end
    endtask

    always @(posedge clk)
    begin : monitor
        alu_rsp_word_t want;
        if (rst_n)
        begin
            if (req.valid && req.ready)
                pending_rsp_q.push_back(alu_eval(alu_cmd_t'(req.command),
                                                 req.operand_a, req.operand_b));
            if (rsp.valid && rsp.ready)
            begin
                if (pending_rsp_q.size() == 0)
                begin
                    $display("%0t: unexpected word, expected none, actual %h", $time,
                             rsp.result);
                    mismatches++;
                end
                else
                begin
                    want = pending_rsp_q.pop_front();
                    check_field("result", want.result, rsp.result);
                    check_field("zero_flag", WORD_W'(want.zero), WORD_W'(rsp.zero_flag));
                    check_field("overflow_flag", WORD_W'(want.ovf),
                                WORD_W'(rsp.overflow_flag));
                    check_field("negative_flag", WORD_W'(want.neg),
                                WORD_W'(rsp.negative_flag));
                end
            end
            pending_cnt <= pending_rsp_q.size();
        end
    end

endmodule

// File: tb/sv/alu_32bit_eight_op_with_flags_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// alu_32bit_eight_op_with_flags_unit_tb
// Drives directed corner words and random words of all eight commands through
// the ALU under several idle and stall mixes, including one long output
// hold-off, and reports the verdict of the result checker.
// ----------------------------------------------------------------------------
module alu_32bit_eight_op_with_flags_unit_tb;
    import alu_pkg::*;

    localparam int HALF_PERIOD      = 6;
    localparam int RESET_CYCLES     = 8;
    localparam int RANDOM_PER_PHASE = 357;
    localparam int HOLD_CYCLES      = 200;
    localparam int DRAIN_CYCLES     = 40;
    localparam int CYCLE_LIMIT      = 200000;

    localparam logic [WORD_W-1:0] MIN_S = 32'h8000_0000;
    localparam logic [WORD_W-1:0] MAX_S = 32'h7fff_ffff;
    localparam logic [WORD_W-1:0] ONES  = 32'hffff_ffff;

    logic        clk   = 1'b0;
    logic        rst_n = 1'b0;
    int unsigned fail_count;
    int unsigned pending;
    int unsigned idle_pct    = 0;
    int unsigned stall_pct   = 0;
    int unsigned hold_asked  = 0;
    int unsigned hold_served = 0;
    int unsigned cycle_cnt   = 0;

    alu_req_if req_if ();
    alu_rsp_if rsp_if ();

    alu_32bit_eight_op_with_flags_unit i_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_if),
        .rsp   (rsp_if)
    );

    alu_result_checker i_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .req        (req_if),
        .rsp        (rsp_if),
        .fail_count (fail_count),
        .pending    (pending)
    );

    always #(HALF_PERIOD) clk = ~clk;

    function automatic logic [WORD_W-1:0] pick_operand();
        case ($urandom_range(9))
            0, 1, 2, 3: return $urandom;
            4:          return $urandom_range(16) - 8;
            5:          return 32'h1 << $urandom_range(31);
            6:          return ~(32'h1 << $urandom_range(31));
            7:
            begin
                case ($urandom_range(4))
                    0:       return '0;
                    1:       return 32'h1;
                    2:       return ONES;
                    3:       return MIN_S;
                    default: return MAX_S;
                endcase
            end
            8:          return $urandom & $urandom;
            default:    return $urandom >> $urandom_range(31);
        endcase
    endfunction

    task automatic send_word(input alu_cmd_t cmd, input logic [WORD_W-1:0] a,
                             input logic [WORD_W-1:0] b);
        while ($urandom_range(99) < idle_pct)
        begin
            req_if.valid <= 1'b0;
            @(posedge clk);
        end
        req_if.valid     <= 1'b1;
        req_if.command   <= cmd;
        req_if.operand_a <= a;
        req_if.operand_b <= b;
        do
            @(posedge clk);
        while (!req_if.ready);
    endtask

    initial
    begin : rsp_ready_gen
        rsp_if.ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_served != hold_asked)
            begin
                rsp_if.ready <= 1'b0;
                repeat (HOLD_CYCLES - 1) @(posedge clk);
                hold_served++;
            end
            else
                rsp_if.ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    initial
    begin : watchdog
        while (cycle_cnt < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_cnt++;
        end
        $display("FAIL alu_32bit_eight_op_with_flags_unit");
        $finish;
    end

    initial
    begin : stimulus
        req_if.valid     <= 1'b0;
        req_if.command   <= CMD_AND;
        req_if.operand_a <= '0;
        req_if.operand_b <= '0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_word(CMD_AND, ONES, 32'h5555_5555);
        send_word(CMD_AND, 32'haaaa_aaaa, 32'h5555_5555);
        send_word(CMD_OR,  32'haaaa_aaaa, 32'h5555_5555);
        send_word(CMD_OR,  '0, '0);
        send_word(CMD_XOR, ONES, ONES);
        send_word(CMD_XOR, 32'h1234_5678, ONES);
        send_word(CMD_SHR, ONES, ONES);
        send_word(CMD_SHR, 32'h1, '0);
        send_word(CMD_SHL, MIN_S, ONES);
        send_word(CMD_SHL, 32'h4000_0000, '0);
        send_word(CMD_ADD, MAX_S, 32'h1);
        send_word(CMD_ADD, MIN_S, MIN_S);
        send_word(CMD_ADD, ONES, 32'h1);
        send_word(CMD_ADD, MIN_S, ONES);
        send_word(CMD_ADD, MAX_S, MIN_S);
        send_word(CMD_MUL, MIN_S, ONES);
        send_word(CMD_MUL, 32'h0001_0000, 32'h0001_0000);
        send_word(CMD_MUL, 32'hffff_fffd, 32'h7);
        send_word(CMD_DIV, 32'h1234_5678, '0);
        send_word(CMD_DIV, MIN_S, ONES);
        send_word(CMD_DIV, 32'hffff_fff9, 32'h2);
        send_word(CMD_DIV, 32'h7, 32'hffff_fffe);
        send_word(CMD_DIV, '0, 32'h5);
        send_word(CMD_DIV, MAX_S, 32'h1);
        send_word(CMD_DIV, 32'h1, MIN_S);

        for (int p = 0; p < 4; p++)
        begin
            case (p)
                0:
                begin
                    idle_pct   <= 0;
                    stall_pct  <= 0;
                    hold_asked <= hold_asked + 1;
                end
                1:
                begin
                    idle_pct  <= 50;
                    stall_pct <= 0;
                end
                2:
                begin
                    idle_pct  <= 0;
                    stall_pct <= 50;
                end
                default:
                begin
                    idle_pct  <= 15;
                    stall_pct <= 15;
                end
            endcase
            for (int i = 0; i < RANDOM_PER_PHASE; i++)
                send_word(alu_cmd_t'($urandom_range(7)), pick_operand(), pick_operand());
        end
        req_if.valid <= 1'b0;

        do
            @(posedge clk);
        while (pending != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (fail_count == 0 && pending == 0)
            $display("PASS alu_32bit_eight_op_with_flags_unit");
        else
            $display("FAIL alu_32bit_eight_op_with_flags_unit");
        $finish;
    end

endmodule
